// ===== sv/schit_pkg.sv =====
// package for the segment/circle hit test
// widths and constants shared by the input interface, multiplier and top level
`default_nettype none
package schit_pkg;
    localparam int COORD_W   = 24;
    localparam int FRAC_BITS = 8;
    localparam int RAD_W     = COORD_W - 1;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int R2_W      = 2 * RAD_W;
    localparam int TOL_W     = 16;
    localparam int TOL2_W    = 2 * TOL_W;
    localparam int MUL_W     = SUM_W + 1;
    localparam int MUL_H     = MUL_W / 2;
    localparam int MULP_W    = 2 * MUL_W;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(((1 << FRAC_BITS) + 5) / 10);
    localparam logic [ADDR_W-1:0] ADDR_TOL = '0;
endpackage
`default_nettype wire

// ===== sv/schit_if.sv =====
// item channels of the segment/circle hit test
// depends on schit_pkg
`default_nettype none
interface schit_in_if import schit_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [RAD_W-1:0]   radius;
    modport source (output valid, start_x, start_y, end_x, end_y, center_x, center_y,
                    radius, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, center_x, center_y,
                    radius, output ready);
endinterface

interface schit_out_if;
    logic valid;
    logic ready;
    logic hit;
    logic end_inside;
    modport source (output valid, hit, end_inside, input ready);
    modport sink   (input valid, hit, end_inside, output ready);
endinterface
`default_nettype wire

// ===== sv/segment_circle_hit_test_top.sv =====
// top level of the segment/circle hit test: seven-stage pipeline, apb register
// depends on schit_pkg, schit_if and schit_mul
//
//  channel | dir | handshake     | payload
//  i_in    | in  | valid/ready   | start, end, center (x, y), radius
//  o_out   | out | valid/ready   | hit, end_inside
//  apb     | in  | psel/penable  | on_segment_tolerance at byte address 0
//
// one item per cycle while the output is not stalled; seven register stages
// the depth is set by the two-stage wide multipliers for the squared terms
// synchronous active-low reset clears valid bits and restores the tolerance
// a stalled output freezes the whole pipeline; nothing is dropped or repeated
`default_nettype none
module segment_circle_hit_test_top import schit_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    schit_in_if.sink               i_in,
    schit_out_if.source            o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);
    logic [TOL_W-1:0] r_tol;
    logic [7:1]       r_vld;
    logic             en;

    // configuration register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_TOL) begin
            r_tol <= pwdata[TOL_W-1:0];
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr == ADDR_TOL) prdata = DATA_W'(r_tol);
    end

    // pipeline advance
    assign en         = !r_vld[7] || o_out.ready;
    assign i_in.ready = en;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[6:1], i_in.valid};
        end
    end

    // stage 1: differences
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_ax, r_ay, r_bx, r_by;
    logic        [RAD_W-1:0]  r_r1;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx <= $signed({i_in.end_x[COORD_W-1], i_in.end_x})
                  - $signed({i_in.start_x[COORD_W-1], i_in.start_x});
            r_dy <= $signed({i_in.end_y[COORD_W-1], i_in.end_y})
                  - $signed({i_in.start_y[COORD_W-1], i_in.start_y});
            r_ax <= $signed({i_in.center_x[COORD_W-1], i_in.center_x})
                  - $signed({i_in.start_x[COORD_W-1], i_in.start_x});
            r_ay <= $signed({i_in.center_y[COORD_W-1], i_in.center_y})
                  - $signed({i_in.start_y[COORD_W-1], i_in.start_y});
            r_bx <= $signed({i_in.center_x[COORD_W-1], i_in.center_x})
                  - $signed({i_in.end_x[COORD_W-1], i_in.end_x});
            r_by <= $signed({i_in.center_y[COORD_W-1], i_in.center_y})
                  - $signed({i_in.end_y[COORD_W-1], i_in.end_y});
            r_r1 <= i_in.radius;
        end
    end

    // stage 2: narrow products
    logic signed [PROD_W-1:0] r_axax, r_ayay, r_bxbx, r_byby, r_dxdx, r_dydy;
    logic signed [PROD_W-1:0] r_axdx, r_aydy, r_bxdx, r_bydy, r_axdy, r_aydx;
    logic        [R2_W-1:0]   r_rr;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_axax <= r_ax * r_ax;
            r_ayay <= r_ay * r_ay;
            r_bxbx <= r_bx * r_bx;
            r_byby <= r_by * r_by;
            r_dxdx <= r_dx * r_dx;
            r_dydy <= r_dy * r_dy;
            r_axdx <= r_ax * r_dx;
            r_aydy <= r_ay * r_dy;
            r_bxdx <= r_bx * r_dx;
            r_bydy <= r_by * r_dy;
            r_axdy <= r_ax * r_dy;
            r_aydx <= r_ay * r_dx;
            r_rr   <= r_r1 * r_r1;
        end
    end

    // stage 3: sums
    logic        [SUM_W-1:0] r_da, r_db, r_len2;
    logic signed [SUM_W-1:0] r_dot, r_past, r_cross;
    logic        [R2_W-1:0]  r_r2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_da    <= SUM_W'(unsigned'(r_axax)) + SUM_W'(unsigned'(r_ayay));
            r_db    <= SUM_W'(unsigned'(r_bxbx)) + SUM_W'(unsigned'(r_byby));
            r_len2  <= SUM_W'(unsigned'(r_dxdx)) + SUM_W'(unsigned'(r_dydy));
            r_dot   <= SUM_W'(r_axdx) + SUM_W'(r_aydy);
            r_past  <= SUM_W'(r_bxdx) + SUM_W'(r_bydy);
            r_cross <= SUM_W'(r_axdy) - SUM_W'(r_aydx);
            r_r2    <= r_rr;
        end
    end

    // stage 4: end-point test, slack operand selection, magnitudes
    logic             r_in4, r_lz4, r_nd4;
    logic [SUM_W-1:0] r_slk, r_crs, r_len4;
    logic [R2_W-1:0]  r_r24;
    logic [TOL2_W-1:0] r_tol2;
    logic             dot_neg, past_pos;
    assign dot_neg  = r_dot[SUM_W-1];
    assign past_pos = !r_past[SUM_W-1] && (r_past != '0);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in4  <= (r_da < SUM_W'(r_r2)) || (r_db < SUM_W'(r_r2));
            r_lz4  <= (r_len2 == '0);
            r_nd4  <= dot_neg || past_pos;
            r_slk  <= dot_neg ? SUM_W'(-r_dot) : SUM_W'(r_past);
            r_crs  <= r_cross[SUM_W-1] ? SUM_W'(-r_cross) : SUM_W'(r_cross);
            r_len4 <= r_len2;
            r_r24  <= r_r2;
            r_tol2 <= r_tol * r_tol;
        end
    end

    // stages 5 and 6: wide products
    logic [MULP_W-1:0] vv, cc, rl, tl;
    schit_mul u_mul_vv (.i_clk, .i_en(en), .i_a(MUL_W'(r_slk)), .i_b(MUL_W'(r_slk)),
                        .o_p(vv));
    schit_mul u_mul_cc (.i_clk, .i_en(en), .i_a(MUL_W'(r_crs)), .i_b(MUL_W'(r_crs)),
                        .o_p(cc));
    schit_mul u_mul_rl (.i_clk, .i_en(en), .i_a(MUL_W'(r_r24)), .i_b(MUL_W'(r_len4)),
                        .o_p(rl));
    schit_mul u_mul_tl (.i_clk, .i_en(en), .i_a(MUL_W'(r_tol2)), .i_b(MUL_W'(r_len4)),
                        .o_p(tl));

    // flags ride along with the multipliers
    logic r_in5, r_lz5, r_nd5, r_in6, r_lz6, r_nd6;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in5 <= r_in4;
            r_lz5 <= r_lz4;
            r_nd5 <= r_nd4;
            r_in6 <= r_in5;
            r_lz6 <= r_lz5;
            r_nd6 <= r_nd5;
        end
    end

    // stage 7: final compares into the output register
    logic onseg, near;
    logic r_hit, r_ins;
    assign onseg = !r_nd6 || ({vv[MULP_W-3:0], 2'b00} <= tl);
    assign near  = (cc <= rl);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ins <= r_in6;
            r_hit <= r_in6 || (!r_lz6 && onseg && near);
        end
    end

    assign o_out.valid      = r_vld[7];
    assign o_out.hit        = r_hit;
    assign o_out.end_inside = r_ins;

    // an end point inside always counts as a hit
    a_inside_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (!o_out.end_inside || o_out.hit))
        else $error("end_inside without hit");

    // a stalled pipeline keeps its occupancy
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved during stall");

    // input is refused only while a finished item waits
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input refused without output stall");
endmodule
`default_nettype wire

// ===== sv/schit_mul.sv =====
// two-stage unsigned multiplier built from four half-width partial products
// depends on schit_pkg
`default_nettype none
module schit_mul import schit_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [MUL_W-1:0]  i_a,
    input  wire logic [MUL_W-1:0]  i_b,
    output logic      [MULP_W-1:0] o_p
);
    logic [2*MUL_H-1:0] r_pll, r_plh, r_phl, r_phh;
    logic [MULP_W-1:0]  r_p;

    // partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pll <= i_a[MUL_H-1:0]     * i_b[MUL_H-1:0];
            r_plh <= i_a[MUL_H-1:0]     * i_b[MUL_W-1:MUL_H];
            r_phl <= i_a[MUL_W-1:MUL_H] * i_b[MUL_H-1:0];
            r_phh <= i_a[MUL_W-1:MUL_H] * i_b[MUL_W-1:MUL_H];
        end
    end

    // recombine
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= MULP_W'(r_pll)
                 + (MULP_W'(r_plh) << MUL_H)
                 + (MULP_W'(r_phl) << MUL_H)
                 + (MULP_W'(r_phh) << (2 * MUL_H));
        end
    end

    assign o_p = r_p;
endmodule
`default_nettype wire
